// ===== design/atsc_pkg.sv =====
package atsc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned WIDE_W = 64;
    localparam int unsigned ADDR_W = 5;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_MAX  = 2'd1;
    localparam logic [1:0] CLAMP_MIN  = 2'd2;

    localparam logic [2:0] REG_SAFETY  = 3'd0;
    localparam logic [2:0] REG_TOL     = 3'd1;
    localparam logic [2:0] REG_SMIN    = 3'd2;
    localparam logic [2:0] REG_SMAX    = 3'd3;
    localparam logic [2:0] REG_ORDER   = 3'd4;
    localparam logic [2:0] REG_MODE    = 3'd5;
    localparam logic [2:0] REG_INIT    = 3'd6;

    localparam logic [31:0] RST_SAFETY = 32'd16777216;
    localparam logic [31:0] RST_TOL    = 32'd167772;
    localparam logic [31:0] RST_SMIN   = 32'd16777;
    localparam logic [31:0] RST_SMAX   = 32'd1677722;
    localparam logic [31:0] RST_INIT   = 32'd167772;

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q1,
        S_Q2,
        S_XMUL,
        S_RSET,
        S_RPOW,
        S_RCMP,
        S_GAIN,
        S_Q3,
        S_GMUL,
        S_FMUL,
        S_CLAMP,
        S_OUT
    } state_t;

endpackage

// ===== design/atsc_if.sv =====
interface atsc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] error_estimate;

    modport source (output valid, output error_estimate, input ready);
    modport sink (input valid, input error_estimate, output ready);
endinterface

interface atsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_step;
    logic [31:0] proposed_step;
    logic [1:0]  clamp_code;

    modport source (output valid, output new_step, output proposed_step, output clamp_code,
                    input ready);
    modport sink (input valid, input new_step, input proposed_step, input clamp_code,
                  output ready);
endinterface

// ===== design/adaptive_time_step_controller.sv =====
// The work grows from elementary mode with order 1 to predictive mode with order 3; a zero
// error, or a zero previous step in predictive mode, goes straight to the clamp.
// Each quotient comes from a radix-2 restoring divider and each 64-bit product from
// one shared 32x32 multiplier; the 64-bit root search dominates at higher orders.
// One item is in work at a time: a new error is taken only after the last result is accepted.
// Reset (rst_n, asynchronous, low) loads default registers, clears the error history.
module adaptive_time_step_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [atsc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    atsc_in_if.sink                     err_in,
    atsc_out_if.source                  step_out
);

    localparam logic [63:0] ONES64 = {64{1'b1}};

    logic [31:0] safety_reg, tol_reg, smin_reg, smax_reg, init_reg;
    logic [1:0]  order_reg;
    logic        mode_reg;
    logic [31:0] cur_reg, prev_reg, perr_reg;
    logic        first_reg;

    atsc_pkg::state_t state_reg, state_next;
    logic [31:0] e_reg, e_next, ep_reg, ep_next;
    logic        pred_reg, pred_next, p1_reg, p1_next, p3_reg, p3_next;
    logic [63:0] x_reg, x_next, y_reg, y_next, g_reg, g_next, t_reg, t_next;
    logic [63:0] pw_reg, pw_next;
    logic [5:0]  bidx_reg, bidx_next;
    logic        more_reg, more_next;
    logic [31:0] prop_reg, prop_next, new_reg, new_next;
    logic [1:0]  code_reg, code_next;
    logic        upd;

    logic [63:0] ma_reg, ma_next, mb_reg, mb_next, acc_reg, acc_next, prod_reg, prod_next;
    logic        sat_reg, sat_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next, dv_reg, dv_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic        mul_start, div_start;
    logic [63:0] mul_a, mul_b;
    logic [31:0] div_a, div_b;
    logic        is_mul, is_div, mul_done, div_done;
    logic [63:0] mres;
    logic [1:0]  k;
    logic [31:0] mop_a, mop_b;
    logic [63:0] addend;
    logic [64:0] msum;
    logic [63:0] acc_step;
    logic        sat_step;
    logic [63:0] quo;
    logic [32:0] shifted;
    logic        ge;
    logic [63:0] cand;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            atsc_pkg::REG_SAFETY: prdata = safety_reg;
            atsc_pkg::REG_TOL:    prdata = tol_reg;
            atsc_pkg::REG_SMIN:   prdata = smin_reg;
            atsc_pkg::REG_SMAX:   prdata = smax_reg;
            atsc_pkg::REG_ORDER:  prdata = {30'd0, order_reg};
            atsc_pkg::REG_MODE:   prdata = {31'd0, mode_reg};
            atsc_pkg::REG_INIT:   prdata = init_reg;
            default:              prdata = 32'd0;
        endcase
    end

    // Shared unit: 64-bit fractional multiply with saturation, and restoring divider.
    assign is_mul = (state_reg == atsc_pkg::S_XMUL) || (state_reg == atsc_pkg::S_RPOW) ||
                    (state_reg == atsc_pkg::S_GAIN) || (state_reg == atsc_pkg::S_GMUL) ||
                    (state_reg == atsc_pkg::S_FMUL);
    assign is_div = (state_reg == atsc_pkg::S_Q1) || (state_reg == atsc_pkg::S_Q2) ||
                    (state_reg == atsc_pkg::S_Q3);
    assign k       = cnt_reg[2:1];
    assign mop_a   = k[1] ? ma_reg[31:0] : ma_reg[63:32];
    assign mop_b   = k[0] ? mb_reg[31:0] : mb_reg[63:32];
    assign addend  = (k == 2'd3) ? {32'd0, prod_reg[63:32]} : prod_reg;
    assign msum    = {1'b0, acc_reg} + {1'b0, addend};
    assign shifted = {rem_reg, dvd_reg[63]};
    assign ge      = shifted >= {1'b0, dv_reg};
    assign quo     = {dvd_reg[62:0], ge};

    always_comb
    begin
        if (k == 2'd0)
        begin
            acc_step = {prod_reg[31:0], 32'd0};
            sat_step = |prod_reg[63:32];
        end
        else
        begin
            acc_step = msum[63:0];
            sat_step = sat_reg | msum[64];
        end
    end

    always_comb
    begin
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        prod_next = prod_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        if (mul_start)
        begin
            ma_next  = mul_a;
            mb_next  = mul_b;
            sat_next = 1'b0;
            cnt_next = 6'd0;
        end
        else if (div_start)
        begin
            dvd_next = {div_a, 32'd0};
            rem_next = 32'd0;
            dv_next  = div_b;
            cnt_next = 6'd0;
        end
        else if (is_mul)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (!cnt_reg[0])
            begin
                prod_next = {32'd0, mop_a} * {32'd0, mop_b};
            end
            else
            begin
                acc_next = acc_step;
                sat_next = sat_step;
            end
        end
        else if (is_div)
        begin
            cnt_next = cnt_reg + 6'd1;
            rem_next = ge ? 32'(shifted - {1'b0, dv_reg}) : shifted[31:0];
            dvd_next = quo;
        end
    end

    assign mul_done = is_mul && (cnt_reg[2:0] == 3'd7);
    assign div_done = is_div && (cnt_reg == 6'd63);
    assign mres     = sat_step ? ONES64 : acc_step;
    assign cand     = y_reg | (64'd1 << bidx_reg);

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        ep_next    = ep_reg;
        pred_next  = pred_reg;
        p1_next    = p1_reg;
        p3_next    = p3_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        g_next     = g_reg;
        t_next     = t_reg;
        pw_next    = pw_reg;
        bidx_next  = bidx_reg;
        more_next  = more_reg;
        prop_next  = prop_reg;
        new_next   = new_reg;
        code_next  = code_reg;
        upd        = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul_a      = ma_reg;
        mul_b      = mb_reg;
        div_a      = tol_reg;
        div_b      = e_reg;
        unique case (state_reg)
            atsc_pkg::S_IDLE:
            begin
                if (err_in.valid)
                begin
                    e_next    = err_in.error_estimate;
                    ep_next   = first_reg ? err_in.error_estimate : perr_reg;
                    pred_next = !mode_reg;
                    p1_next   = order_reg[1] == 1'b0;
                    p3_next   = order_reg == 2'd3;
                    if ((err_in.error_estimate == 32'd0) || (!mode_reg && prev_reg == 32'd0))
                    begin
                        prop_next  = 32'hFFFF_FFFF;
                        state_next = atsc_pkg::S_CLAMP;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_a      = tol_reg;
                        div_b      = err_in.error_estimate;
                        state_next = atsc_pkg::S_Q1;
                    end
                end
            end
            atsc_pkg::S_Q1:
            begin
                if (div_done)
                begin
                    if (pred_reg)
                    begin
                        t_next     = quo;
                        div_start  = 1'b1;
                        div_a      = ep_reg;
                        div_b      = e_reg;
                        state_next = atsc_pkg::S_Q2;
                    end
                    else
                    begin
                        x_next     = quo;
                        y_next     = 64'd0;
                        bidx_next  = 6'd63;
                        state_next = atsc_pkg::S_RSET;
                    end
                end
            end
            atsc_pkg::S_Q2:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = t_reg;
                    mul_b      = quo;
                    state_next = atsc_pkg::S_XMUL;
                end
            end
            atsc_pkg::S_XMUL:
            begin
                if (mul_done)
                begin
                    x_next     = mres;
                    y_next     = 64'd0;
                    bidx_next  = 6'd63;
                    state_next = atsc_pkg::S_RSET;
                end
            end
            atsc_pkg::S_RSET:
            begin
                t_next = cand;
                if (p1_reg)
                begin
                    pw_next    = cand;
                    state_next = atsc_pkg::S_RCMP;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = cand;
                    mul_b      = cand;
                    more_next  = p3_reg;
                    state_next = atsc_pkg::S_RPOW;
                end
            end
            atsc_pkg::S_RPOW:
            begin
                if (mul_done)
                begin
                    if (more_reg)
                    begin
                        more_next = 1'b0;
                        mul_start = 1'b1;
                        mul_a     = mres;
                        mul_b     = t_reg;
                    end
                    else
                    begin
                        pw_next    = mres;
                        state_next = atsc_pkg::S_RCMP;
                    end
                end
            end
            atsc_pkg::S_RCMP:
            begin
                if (pw_reg <= x_reg)
                begin
                    y_next = t_reg;
                end
                if (bidx_reg == 6'd0)
                begin
                    mul_start  = 1'b1;
                    mul_a      = {16'd0, safety_reg, 16'd0};
                    mul_b      = {32'd0, cur_reg};
                    state_next = atsc_pkg::S_GAIN;
                end
                else
                begin
                    bidx_next  = bidx_reg - 6'd1;
                    state_next = atsc_pkg::S_RSET;
                end
            end
            atsc_pkg::S_GAIN:
            begin
                if (mul_done)
                begin
                    g_next = mres;
                    if (pred_reg)
                    begin
                        div_start  = 1'b1;
                        div_a      = cur_reg;
                        div_b      = prev_reg;
                        state_next = atsc_pkg::S_Q3;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = mres;
                        mul_b      = y_reg;
                        state_next = atsc_pkg::S_FMUL;
                    end
                end
            end
            atsc_pkg::S_Q3:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = g_reg;
                    mul_b      = quo;
                    state_next = atsc_pkg::S_GMUL;
                end
            end
            atsc_pkg::S_GMUL:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mres;
                    mul_b      = y_reg;
                    state_next = atsc_pkg::S_FMUL;
                end
            end
            atsc_pkg::S_FMUL:
            begin
                if (mul_done)
                begin
                    prop_next  = (mres[63:40] != 24'd0) ? 32'hFFFF_FFFF : mres[39:8];
                    state_next = atsc_pkg::S_CLAMP;
                end
            end
            atsc_pkg::S_CLAMP:
            begin
                priority if (prop_reg > smax_reg)
                begin
                    new_next  = smax_reg;
                    code_next = atsc_pkg::CLAMP_MAX;
                end
                else if (prop_reg < smin_reg)
                begin
                    new_next  = smin_reg;
                    code_next = atsc_pkg::CLAMP_MIN;
                end
                else
                begin
                    new_next  = prop_reg;
                    code_next = atsc_pkg::CLAMP_NONE;
                end
                upd        = 1'b1;
                state_next = atsc_pkg::S_OUT;
            end
            atsc_pkg::S_OUT:
            begin
                if (step_out.ready)
                begin
                    state_next = atsc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = atsc_pkg::S_IDLE;
            end
        endcase
    end

    assign err_in.ready           = state_reg == atsc_pkg::S_IDLE;
    assign step_out.valid         = state_reg == atsc_pkg::S_OUT;
    assign step_out.new_step      = new_reg;
    assign step_out.proposed_step = prop_reg;
    assign step_out.clamp_code    = code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= atsc_pkg::S_IDLE;
            safety_reg <= atsc_pkg::RST_SAFETY;
            tol_reg    <= atsc_pkg::RST_TOL;
            smin_reg   <= atsc_pkg::RST_SMIN;
            smax_reg   <= atsc_pkg::RST_SMAX;
            order_reg  <= 2'd1;
            mode_reg   <= 1'b0;
            init_reg   <= atsc_pkg::RST_INIT;
            cur_reg    <= atsc_pkg::RST_INIT;
            prev_reg   <= atsc_pkg::RST_INIT;
            perr_reg   <= 32'd0;
            first_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (upd)
            begin
                perr_reg  <= e_reg;
                first_reg <= 1'b0;
                prev_reg  <= cur_reg;
                cur_reg   <= new_next;
            end
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    atsc_pkg::REG_SAFETY: safety_reg <= pwdata;
                    atsc_pkg::REG_TOL:    tol_reg    <= pwdata;
                    atsc_pkg::REG_SMIN:   smin_reg   <= pwdata;
                    atsc_pkg::REG_SMAX:   smax_reg   <= pwdata;
                    atsc_pkg::REG_ORDER:  order_reg  <= pwdata[1:0];
                    atsc_pkg::REG_MODE:   mode_reg   <= pwdata[0];
                    atsc_pkg::REG_INIT:
                    begin
                        init_reg <= pwdata;
                        cur_reg  <= pwdata;
                        prev_reg <= pwdata;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        ep_reg   <= ep_next;
        pred_reg <= pred_next;
        p1_reg   <= p1_next;
        p3_reg   <= p3_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        g_reg    <= g_next;
        t_reg    <= t_next;
        pw_reg   <= pw_next;
        bidx_reg <= bidx_next;
        more_reg <= more_next;
        prop_reg <= prop_next;
        new_reg  <= new_next;
        code_reg <= code_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        acc_reg  <= acc_next;
        sat_reg  <= sat_next;
        prod_reg <= prod_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
        cnt_reg  <= cnt_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(err_in.ready && step_out.valid))
        else $error("input accepted while a result is pending");

    a_max_code: assert property (@(posedge clk) disable iff (!rst_n)
        step_out.valid && (step_out.clamp_code == atsc_pkg::CLAMP_MAX) |->
        (step_out.new_step == smax_reg) && (step_out.proposed_step > smax_reg))
        else $error("maximum clamp does not match limit");

    a_none_code: assert property (@(posedge clk) disable iff (!rst_n)
        step_out.valid && (step_out.clamp_code == atsc_pkg::CLAMP_NONE) |->
        step_out.new_step == step_out.proposed_step)
        else $error("unclamped result differs from proposal");

    a_step_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == atsc_pkg::S_CLAMP |=> (cur_reg == new_reg) && !first_reg)
        else $error("current step not advanced");

endmodule
